/* rtl/spm_pkg.sv */
// Shared types and codes of the slotted page space manager.
// No dependencies; every other file except spm_if imports this package.
package spm_pkg;

  localparam int MAX_SLOTS_DEF    = 32;
  localparam int HEADER_BYTES_DEF = 24;
  localparam logic [15:0] PAGE_SIZE_RST = 16'd4096;
  localparam logic [17:0] DIR_ENTRY_BYTES = 18'd4;

  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_GET    = 3'd2;
  localparam logic [2:0] KIND_UPDATE = 3'd3;
  localparam logic [2:0] KIND_ERASE  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_NOSPACE  = 3'd3;
  localparam logic [2:0] ST_CORRUPT  = 3'd4;

  typedef enum logic [2:0] {
    RS_ERR, RS_ALLOC, RS_GET, RS_ERASE, RS_INPL, RS_MOVE
  } res_sel_t;

  typedef struct packed {
    logic       latch_in;
    logic       init;
    logic       rd_en;
    logic       rd_slot;     // read address from slot field, else from index
    logic       idx_clr;
    logic       scan_chk;    // look for the first tombstone
    logic       cmp_start;
    logic       pass_clr;
    logic       pass_chk;
    logic       take_best;
    logic       mv_commit;
    logic       cmp_finish;
    logic       alloc;
    logic       erase_wr;
    logic       inpl_wr;
    logic       emit;
    res_sel_t   res;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       len_zero;
    logic       idx_end;
    logic       found;
    logic       full;
    logic       short_ins;
    logic       short_upd;
    logic       slot_oor;
    logic       rd_len_zero;
    logic       corrupt;
    logic       fits;
    logic       best_v;
    logic       best_bad;
    logic       out_busy;
  } sts_t;

endpackage

/* rtl/spm_if.sv */
// Valid/ready channel interfaces for commands and results.
// Depends on nothing.
interface spm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] slot;
  logic [15:0] length;
  modport source (output valid, kind, slot, length, input ready);
  modport sink   (input valid, kind, slot, length, output ready);
endinterface

interface spm_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  status;
  logic [5:0]  slot_out;
  logic [15:0] offset;
  logic [15:0] length_out;
  logic [15:0] move_from;
  logic        last;
  modport source (output valid, result_kind, status, slot_out, offset, length_out,
                  move_from, last, input ready);
  modport sink   (input valid, result_kind, status, slot_out, offset, length_out,
                  move_from, last, output ready);
endinterface

/* rtl/spm_dp.sv */
// Datapath: page registers, slot directory memories, compaction cursor, result register.
// Depends on spm_pkg; driven by spm_ctrl commands.
module spm_dp import spm_pkg::*; #(
  parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_slot,
  input  logic [15:0] in_length,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_result_kind,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot_id,
  output logic [15:0] out_offset,
  output logic [15:0] out_length,
  output logic [15:0] out_move_from,
  output logic        out_last
);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [15:0] HDR = 16'(HEADER_BYTES);

  logic [15:0] mem_off [MAX_SLOTS];
  logic [15:0] mem_len [MAX_SLOTS];

  logic [15:0] page_r, slot_r, len_r, free_off_r, free_bytes_r;
  logic [2:0]  kind_r;
  logic [CW-1:0] n_r, idx_r;
  logic [AW-1:0] rd_idx_r, fid_r, best_r;
  logic [15:0] rd_off_r, rd_len_r, best_off_r, best_len_r, cur_r;
  logic        found_r, best_v_r;
  logic [MAX_SLOTS-1:0] seen_r;

  logic        ov_r, ork_r, olast_r;
  logic [2:0]  ost_r;
  logic [5:0]  osl_r;
  logic [15:0] ooff_r, olen_r, ofrom_r;

  logic        ork_nxt, olast_nxt;
  logic [2:0]  ost_nxt;
  logic [5:0]  osl_nxt;
  logic [15:0] ooff_nxt, olen_nxt, ofrom_nxt;

  logic [AW-1:0] rd_addr, tgt;
  logic [16:0]   need;
  logic [17:0]   tot;
  logic          cand;

  assign rd_addr = cmd.rd_slot ? slot_r[AW-1:0] : idx_r[AW-1:0];
  assign tgt     = (kind_r == KIND_INSERT) ? (found_r ? fid_r : n_r[AW-1:0]) : slot_r[AW-1:0];
  // a new directory entry costs 4 bytes; reuse and relocation do not
  assign need    = {1'b0, len_r} +
                   ((kind_r == KIND_INSERT && !found_r) ? 17'(DIR_ENTRY_BYTES) : 17'd0);
  assign tot     = {2'b00, cur_r} + ({{(18-CW){1'b0}}, n_r} << 2);
  assign cand    = (rd_len_r != 16'd0) && !seen_r[rd_idx_r] &&
                   (!best_v_r || rd_off_r < best_off_r);

  always_comb begin
    sts.kind        = kind_r;
    sts.len_zero    = (len_r == 16'd0);
    sts.idx_end     = (idx_r >= n_r);
    sts.found       = found_r;
    sts.full        = (n_r >= CW'(MAX_SLOTS));
    sts.short_ins   = ({1'b0, free_bytes_r} < need);
    sts.short_upd   = (free_bytes_r < len_r);
    sts.slot_oor    = (slot_r >= {{(16-CW){1'b0}}, n_r});
    sts.rd_len_zero = (rd_len_r == 16'd0);
    sts.corrupt     = (rd_off_r < HDR) ||
                      (({1'b0, rd_off_r} + {1'b0, rd_len_r}) > {1'b0, page_r});
    sts.fits        = (len_r <= rd_len_r);
    sts.best_v      = best_v_r;
    sts.best_bad    = (best_off_r < HDR) ||
                      (({1'b0, best_off_r} + {1'b0, best_len_r}) > {1'b0, page_r});
    sts.out_busy    = ov_r && !out_ready;
  end

  // directory memories
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_off_r <= mem_off[rd_addr];
      rd_len_r <= mem_len[rd_addr];
      rd_idx_r <= rd_addr;
    end
    if (cmd.alloc) begin
      mem_off[tgt] <= free_off_r;
      mem_len[tgt] <= len_r;
    end else if (cmd.erase_wr) begin
      mem_len[slot_r[AW-1:0]] <= 16'd0;
    end else if (cmd.inpl_wr) begin
      mem_len[slot_r[AW-1:0]] <= len_r;
    end else if (cmd.mv_commit) begin
      mem_off[best_r] <= cur_r;
    end
  end

  // page state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r       <= PAGE_SIZE_RST;
      n_r          <= '0;
      free_off_r   <= HDR;
      free_bytes_r <= PAGE_SIZE_RST - HDR;
    end else begin
      if (cfg_we) page_r <= cfg_wdata;
      if (cmd.init) begin
        n_r          <= '0;
        free_off_r   <= HDR;
        free_bytes_r <= (page_r > HDR) ? page_r - HDR : 16'd0;
      end else if (cmd.alloc) begin
        free_off_r   <= free_off_r + len_r;
        free_bytes_r <= free_bytes_r - need[15:0];
        if (kind_r == KIND_INSERT && !found_r) n_r <= n_r + CW'(1);
      end else if (cmd.cmp_finish) begin
        free_off_r   <= cur_r;
        free_bytes_r <= ({2'b00, page_r} > tot) ? page_r - tot[15:0] : 16'd0;
      end
    end
  end

  // command latch, scan index and compaction registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_kind;
      slot_r <= in_slot;
      len_r  <= in_length;
    end
    if (cmd.idx_clr || cmd.pass_clr) idx_r <= '0;
    else if (cmd.rd_en && !cmd.rd_slot) idx_r <= idx_r + CW'(1);
    if (cmd.idx_clr) found_r <= 1'b0;
    else if (cmd.scan_chk && !found_r && rd_len_r == 16'd0) begin
      found_r <= 1'b1;
      fid_r   <= rd_idx_r;
    end
    if (cmd.cmp_start) begin
      seen_r <= '0;
      cur_r  <= HDR;
    end else begin
      if (cmd.take_best) seen_r[best_r] <= 1'b1;
      if (cmd.mv_commit) cur_r <= cur_r + best_len_r;
    end
    if (cmd.pass_clr) best_v_r <= 1'b0;
    else if (cmd.pass_chk && cand) begin
      best_v_r   <= 1'b1;
      best_r     <= rd_idx_r;
      best_off_r <= rd_off_r;
      best_len_r <= rd_len_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_comb begin
    ork_nxt   = 1'b0;
    ost_nxt   = ST_OK;
    osl_nxt   = 6'd0;
    ooff_nxt  = 16'd0;
    olen_nxt  = 16'd0;
    ofrom_nxt = 16'd0;
    olast_nxt = 1'b1;
    unique case (cmd.res)
      RS_ERR:   ost_nxt = cmd.status;
      RS_ALLOC: begin
        osl_nxt = 6'(tgt); ooff_nxt = free_off_r; olen_nxt = len_r;
      end
      RS_GET: begin
        osl_nxt = slot_r[5:0]; ooff_nxt = rd_off_r; olen_nxt = rd_len_r;
      end
      RS_ERASE: osl_nxt = slot_r[5:0];
      RS_INPL: begin
        osl_nxt = slot_r[5:0]; ooff_nxt = rd_off_r; olen_nxt = len_r;
      end
      RS_MOVE: begin
        ork_nxt   = 1'b1;
        olast_nxt = 1'b0;
        osl_nxt   = 6'(best_r);
        ooff_nxt  = cur_r;
        olen_nxt  = best_len_r;
        ofrom_nxt = best_off_r;
      end
      default: ost_nxt = cmd.status;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ork_r   <= ork_nxt;
      ost_r   <= ost_nxt;
      osl_r   <= osl_nxt;
      ooff_r  <= ooff_nxt;
      olen_r  <= olen_nxt;
      ofrom_r <= ofrom_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_result_kind = ork_r;
  assign out_status      = ost_r;
  assign out_slot_id     = osl_r;
  assign out_offset      = ooff_r;
  assign out_length      = olen_r;
  assign out_move_from   = ofrom_r;
  assign out_last        = olast_r;
endmodule

/* rtl/spm_ctrl.sv */
// Controller: command sequencing, directory scans and compaction passes.
// Depends on spm_pkg; drives spm_dp through cmd_t, reads back sts_t.
module spm_ctrl import spm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_ERR   = 5'd2;
  localparam logic [4:0] S_INIT  = 5'd3;
  localparam logic [4:0] S_FRD   = 5'd4;
  localparam logic [4:0] S_FCHK  = 5'd5;
  localparam logic [4:0] S_FDONE = 5'd6;
  localparam logic [4:0] S_SLOT  = 5'd7;
  localparam logic [4:0] S_GET   = 5'd8;
  localparam logic [4:0] S_ERASE = 5'd9;
  localparam logic [4:0] S_INPL  = 5'd10;
  localparam logic [4:0] S_ALLOC = 5'd11;
  localparam logic [4:0] S_CPI   = 5'd12;
  localparam logic [4:0] S_CRD   = 5'd13;
  localparam logic [4:0] S_CCHK  = 5'd14;
  localparam logic [4:0] S_CSEL  = 5'd15;
  localparam logic [4:0] S_CMOVE = 5'd16;
  localparam logic [4:0] S_CPOST = 5'd17;
  localparam logic [4:0] S_RDW   = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic [2:0] err_r, err_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    cmd.res   = RS_ERR;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.latch_in = 1'b1;
        state_nxt    = S_DISP;
      end
      S_DISP: begin
        if (sts.kind == KIND_INIT) begin
          state_nxt = S_INIT;
        end else if (sts.kind == KIND_INSERT) begin
          if (sts.len_zero) begin
            err_nxt = ST_INVALID; state_nxt = S_ERR;
          end else begin
            cmd.idx_clr = 1'b1; state_nxt = S_FRD;
          end
        end else if (sts.kind == KIND_GET || sts.kind == KIND_UPDATE ||
                     sts.kind == KIND_ERASE) begin
          if (sts.slot_oor) begin
            err_nxt = ST_NOTFOUND; state_nxt = S_ERR;
          end else begin
            cmd.rd_en = 1'b1; cmd.rd_slot = 1'b1; state_nxt = S_RDW;
          end
        end else begin
          err_nxt = ST_INVALID; state_nxt = S_ERR;
        end
      end
      S_RDW: state_nxt = S_SLOT;
      S_ERR: if (!sts.out_busy) begin
        cmd.emit = 1'b1; cmd.status = err_r; state_nxt = S_IDLE;
      end
      S_INIT: if (!sts.out_busy) begin
        cmd.init = 1'b1; cmd.emit = 1'b1; cmd.status = ST_OK; state_nxt = S_IDLE;
      end
      S_FRD: begin
        if (sts.idx_end) state_nxt = S_FDONE;
        else begin
          cmd.rd_en = 1'b1; state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        cmd.scan_chk = 1'b1; state_nxt = S_FRD;
      end
      S_FDONE: begin
        if (!sts.found && sts.full) begin
          err_nxt = ST_NOSPACE; state_nxt = S_ERR;
        end else if (sts.short_ins) begin
          cmd.cmp_start = 1'b1; state_nxt = S_CPI;
        end else state_nxt = S_ALLOC;
      end
      S_SLOT: begin
        if (sts.rd_len_zero) begin
          err_nxt = ST_NOTFOUND; state_nxt = S_ERR;
        end else if (sts.kind == KIND_GET) begin
          if (sts.corrupt) begin
            err_nxt = ST_CORRUPT; state_nxt = S_ERR;
          end else state_nxt = S_GET;
        end else if (sts.kind == KIND_ERASE) begin
          state_nxt = S_ERASE;
        end else if (sts.fits) begin
          state_nxt = S_INPL;
        end else if (sts.short_upd) begin
          cmd.cmp_start = 1'b1; state_nxt = S_CPI;
        end else state_nxt = S_ALLOC;
      end
      S_GET: if (!sts.out_busy) begin
        cmd.emit = 1'b1; cmd.res = RS_GET; state_nxt = S_IDLE;
      end
      S_ERASE: if (!sts.out_busy) begin
        cmd.erase_wr = 1'b1; cmd.emit = 1'b1; cmd.res = RS_ERASE; state_nxt = S_IDLE;
      end
      S_INPL: if (!sts.out_busy) begin
        cmd.inpl_wr = 1'b1; cmd.emit = 1'b1; cmd.res = RS_INPL; state_nxt = S_IDLE;
      end
      S_ALLOC: if (!sts.out_busy) begin
        cmd.alloc = 1'b1; cmd.emit = 1'b1; cmd.res = RS_ALLOC; state_nxt = S_IDLE;
      end
      S_CPI: begin
        cmd.pass_clr = 1'b1; state_nxt = S_CRD;
      end
      S_CRD: begin
        if (sts.idx_end) state_nxt = S_CSEL;
        else begin
          cmd.rd_en = 1'b1; state_nxt = S_CCHK;
        end
      end
      S_CCHK: begin
        cmd.pass_chk = 1'b1; state_nxt = S_CRD;
      end
      S_CSEL: begin
        if (!sts.best_v) begin
          cmd.cmp_finish = 1'b1; state_nxt = S_CPOST;
        end else begin
          cmd.take_best = 1'b1;
          // entries outside the page keep their offset and get no move
          state_nxt = sts.best_bad ? S_CPI : S_CMOVE;
        end
      end
      S_CMOVE: if (!sts.out_busy) begin
        cmd.mv_commit = 1'b1; cmd.emit = 1'b1; cmd.res = RS_MOVE; state_nxt = S_CPI;
      end
      S_CPOST: begin
        if ((sts.kind == KIND_INSERT) ? sts.short_ins : sts.short_upd) begin
          err_nxt = ST_NOSPACE; state_nxt = S_ERR;
        end else state_nxt = S_ALLOC;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end
endmodule

/* rtl/slotted_page_space_manager_unit.sv */
// Top level of the slotted page space manager: controller plus datapath.
// Depends on spm_pkg, spm_if, spm_ctrl and spm_dp.
//
//  channel  | direction | handshake          | payload
//  in_ch    | in        | valid/ready        | kind, slot, length
//  out_ch   | out       | valid/ready        | result_kind, status, slot_out, offset,
//           |           |                    | length_out, move_from, last
//  cfg      | in        | cfg_we (no wait)   | cfg_wdata = page bytes
//
// One command at a time. Insert adds a scan over every directory entry in use;
// a compaction makes one pass over the single-port directory memory per pick.
// A result waiting in the output register stalls only the next emit; reset is
// synchronous, active low, and needs no clearing pass.
module slotted_page_space_manager_unit import spm_pkg::*; #(
  parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  spm_in_if.sink      in_ch,
  spm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  cmd_t cmd;
  sts_t sts;

  spm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spm_dp #(
    .MAX_SLOTS    (MAX_SLOTS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_ch.kind),
    .in_slot         (in_ch.slot),
    .in_length       (in_ch.length),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_result_kind (out_ch.result_kind),
    .out_status      (out_ch.status),
    .out_slot_id     (out_ch.slot_out),
    .out_offset      (out_ch.offset),
    .out_length      (out_ch.length_out),
    .out_move_from   (out_ch.move_from),
    .out_last        (out_ch.last)
  );
endmodule

/* verif/spm_checker.sv */
// Checker for the slotted page space manager: watches both channels,
// predicts results from accepted commands and compares. Depends on spm_pkg.
`timescale 1ns / 1ps
module spm_checker import spm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_slot,
  input  logic [15:0] in_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_result_kind,
  input  logic [2:0]  out_status,
  input  logic [5:0]  out_slot_out,
  input  logic [15:0] out_offset,
  input  logic [15:0] out_length_out,
  input  logic [15:0] out_move_from,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          move_count
);
  localparam int NSLOT = MAX_SLOTS_DEF;
  localparam int HDR = HEADER_BYTES_DEF;

  typedef struct packed {
    logic        rk;
    logic [2:0]  st;
    logic [5:0]  sl;
    logic [15:0] off;
    logic [15:0] len;
    logic [15:0] from;
    logic        last;
  } page_res_t;

  page_res_t   want_q[$];
  logic [15:0] pg_size;
  logic [15:0] dir_off [NSLOT];
  logic [15:0] dir_len [NSLOT];
  int unsigned dir_total, free_ptr, free_sz;

  function automatic int unsigned sat_sub(int unsigned a, int unsigned b);
    return a > b ? a - b : 0;
  endfunction

  task automatic push_res(logic rk, logic [2:0] st, int unsigned sl, int unsigned off,
                          int unsigned len, int unsigned from);
    page_res_t r;
    r.rk = rk; r.st = st; r.sl = sl[5:0]; r.off = off[15:0];
    r.len = len[15:0]; r.from = from[15:0]; r.last = !rk;
    want_q.insert(want_q.size(), r);
  endtask

  task automatic pack_page();
    logic [NSLOT-1:0] seen;
    int unsigned cur, best, o, l;
    seen = '0;
    cur = HDR;
    forever begin
      best = dir_total;
      for (int unsigned i = 0; i < dir_total; i++) begin
        if (dir_len[i] == 0 || seen[i]) continue;
        if (best == dir_total || dir_off[i] < dir_off[best]) best = i;
      end
      if (best == dir_total) break;
      seen[best] = 1'b1;
      o = dir_off[best];
      l = dir_len[best];
      if (o < HDR || o + l > pg_size) continue;
      push_res(1'b1, ST_OK, best, cur, l, o);
      dir_off[best] = cur[15:0];
      cur = (cur + l) & 16'hFFFF;
    end
    free_ptr = cur;
    free_sz = sat_sub(pg_size, cur + dir_total * 4) & 16'hFFFF;
  endtask

  task automatic run_command(logic [2:0] kind, logic [15:0] slot, logic [15:0] len);
    int unsigned id, need, o, l;
    bit reuse;
    case (kind)
      KIND_INIT: begin
        dir_total = 0; free_ptr = HDR; free_sz = sat_sub(pg_size, HDR);
        push_res(1'b0, ST_OK, 0, 0, 0, 0);
      end
      KIND_INSERT: begin
        reuse = 0; id = dir_total;
        if (len == 0) begin
          push_res(1'b0, ST_INVALID, 0, 0, 0, 0);
          return;
        end
        for (int unsigned i = 0; i < dir_total; i++)
          if (dir_len[i] == 0) begin reuse = 1; id = i; break; end
        if (!reuse && dir_total >= NSLOT) begin
          push_res(1'b0, ST_NOSPACE, 0, 0, 0, 0);
          return;
        end
        need = len + (reuse ? 0 : 4);
        if (free_sz < need) begin
          pack_page();
          if (free_sz < need) begin
            push_res(1'b0, ST_NOSPACE, 0, 0, 0, 0);
            return;
          end
        end
        o = free_ptr;
        free_ptr = (free_ptr + len) & 16'hFFFF;
        free_sz -= need;
        if (!reuse) dir_total++;
        dir_off[id] = o[15:0];
        dir_len[id] = len;
        push_res(1'b0, ST_OK, id, o, len, 0);
      end
      KIND_GET, KIND_UPDATE, KIND_ERASE: begin
        if (slot >= dir_total || dir_len[slot] == 0) begin
          push_res(1'b0, ST_NOTFOUND, 0, 0, 0, 0);
          return;
        end
        o = dir_off[slot];
        l = dir_len[slot];
        if (kind == KIND_GET) begin
          if (o < HDR || o + l > pg_size) push_res(1'b0, ST_CORRUPT, 0, 0, 0, 0);
          else push_res(1'b0, ST_OK, slot, o, l, 0);
        end else if (kind == KIND_ERASE) begin
          dir_len[slot] = 0;
          push_res(1'b0, ST_OK, slot, 0, 0, 0);
        end else if (len <= l) begin
          dir_len[slot] = len;
          push_res(1'b0, ST_OK, slot, o, len, 0);
        end else begin
          if (free_sz < len) begin
            pack_page();
            if (free_sz < len) begin
              push_res(1'b0, ST_NOSPACE, 0, 0, 0, 0);
              return;
            end
          end
          o = free_ptr;
          dir_off[slot] = o[15:0];
          dir_len[slot] = len;
          free_ptr = (free_ptr + len) & 16'hFFFF;
          free_sz -= len;
          push_res(1'b0, ST_OK, slot, o, len, 0);
        end
      end
      default: push_res(1'b0, ST_INVALID, 0, 0, 0, 0);
    endcase
  endtask

  always @(posedge clk) begin
    page_res_t got, exp_r;
    if (!rst_n) begin
      pg_size = PAGE_SIZE_RST;
      dir_total = 0; free_ptr = HDR; free_sz = PAGE_SIZE_RST - HDR;
      for (int i = 0; i < NSLOT; i++) begin dir_off[i] = '0; dir_len[i] = '0; end
      want_q.delete();
      fail_count = 0; result_count = 0; move_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_result_kind, out_status, out_slot_out, out_offset, out_length_out,
               out_move_from, out_last};
        result_count++;
        if (out_result_kind) move_count++;
        if (want_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = want_q.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp rk=%0d st=%0d sl=%0d off=%0d len=%0d from=%0d last=%0d | got rk=%0d st=%0d sl=%0d off=%0d len=%0d from=%0d last=%0d",
                       exp_r.rk, exp_r.st, exp_r.sl, exp_r.off, exp_r.len, exp_r.from,
                       exp_r.last, got.rk, got.st, got.sl, got.off, got.len, got.from,
                       got.last);
          end
        end
      end
      if (in_valid && in_ready) run_command(in_kind, in_slot, in_length);
      if (cfg_we) pg_size = cfg_wdata;
    end
    pending = want_q.size();
  end
endmodule

/* verif/tb_slotted_page_space_manager_unit.sv */
// Top of the page space manager testbench: clock, reset, command stimulus,
// configuration phases and verdict. Depends on spm_pkg, spm_if, spm_checker and the RTL.
`timescale 1ns / 1ps
module tb_slotted_page_space_manager_unit import spm_pkg::*; ();

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int fail_count, pending, result_count, move_count;
  int idle_cycles, sent;
  bit calm;

  spm_in_if  in_ch ();
  spm_out_if out_ch ();

  initial begin
    in_ch.valid = 1'b0; in_ch.kind = '0; in_ch.slot = '0; in_ch.length = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  slotted_page_space_manager_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  spm_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
    .in_slot(in_ch.slot), .in_length(in_ch.length),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_result_kind(out_ch.result_kind), .out_status(out_ch.status),
    .out_slot_out(out_ch.slot_out), .out_offset(out_ch.offset),
    .out_length_out(out_ch.length_out), .out_move_from(out_ch.move_from),
    .out_last(out_ch.last), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .result_count(result_count),
    .move_count(move_count)
  );

  // receiver stalls
  always @(negedge clk) out_ch.ready <= calm || ($urandom_range(99) >= 19);

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays high from one command to the next; idle gaps and drain drop it
  task automatic send_cmd(logic [2:0] kind, logic [15:0] slot, logic [15:0] len);
    while (!calm && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.kind <= kind; in_ch.slot <= slot; in_ch.length <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_page(logic [15:0] sz);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= sz;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random length: mostly small so the page fills and compacts
  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 16'd0;
    if (r < 6) return 16'($urandom);
    if (r < 80) return 16'($urandom_range(1, 120));
    return 16'($urandom_range(100, 900));
  endfunction

  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 2) send_cmd(KIND_INIT, 16'($urandom), 16'($urandom));
      else if (r < 40) send_cmd(KIND_INSERT, 16'($urandom), pick_len());
      else if (r < 55) send_cmd(KIND_GET, 16'($urandom_range(0, 35)), 16'($urandom));
      else if (r < 75) send_cmd(KIND_UPDATE, 16'($urandom_range(0, 35)), pick_len());
      else if (r < 93) send_cmd(KIND_ERASE, 16'($urandom_range(0, 35)), 16'($urandom));
      else if (r < 96) send_cmd(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom));
      else send_cmd(3'($urandom_range(2, 4)), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    sent = 0; calm = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: every command, field extremes and error cases
    send_cmd(KIND_GET, 16'd0, 16'd0);
    send_cmd(KIND_INSERT, 16'd0, 16'd0);
    send_cmd(KIND_INSERT, 16'hFFFF, 16'd100);
    send_cmd(KIND_INSERT, 16'd0, 16'hFFFF);
    send_cmd(KIND_INSERT, 16'd0, 16'd1);
    send_cmd(KIND_GET, 16'd1, 16'hFFFF);
    send_cmd(KIND_GET, 16'hFFFF, 16'd0);
    send_cmd(KIND_UPDATE, 16'd0, 16'd50);
    send_cmd(KIND_UPDATE, 16'd1, 16'd3000);
    send_cmd(KIND_ERASE, 16'd0, 16'd0);
    send_cmd(KIND_GET, 16'd0, 16'd0);
    send_cmd(KIND_INSERT, 16'd0, 16'd40);
    send_cmd(KIND_UPDATE, 16'd1, 16'd0);
    send_cmd(KIND_INSERT, 16'd0, 16'd2000);
    send_cmd(3'd5, 16'hFFFF, 16'hFFFF);
    send_cmd(3'd7, 16'd0, 16'd0);
    for (int i = 0; i < 34; i++) send_cmd(KIND_INSERT, 16'd0, 16'd8);
    send_cmd(KIND_INIT, 16'd0, 16'd0);
    // small page, below header size
    set_page(16'd16);
    send_cmd(KIND_INIT, 16'd0, 16'd0);
    send_cmd(KIND_INSERT, 16'd0, 16'd4);
    // shrink page under live records to exercise corruption and skipped moves
    set_page(16'd4096);
    send_cmd(KIND_INIT, 16'd0, 16'd0);
    send_cmd(KIND_INSERT, 16'd0, 16'd1000);
    send_cmd(KIND_INSERT, 16'd0, 16'd1000);
    set_page(16'd1500);
    send_cmd(KIND_GET, 16'd1, 16'd0);
    send_cmd(KIND_INSERT, 16'd0, 16'd300);
    // wait for everything before going random
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    set_page(16'd256);
    send_cmd(KIND_INIT, 16'd0, 16'd0);
    random_phase(90);
    calm = 1'b1;
    random_phase(60);
    calm = 1'b0;
    set_page(16'd65535);
    send_cmd(KIND_INIT, 16'd0, 16'd0);
    random_phase(90);
    set_page(16'd600);
    send_cmd(KIND_INIT, 16'd0, 16'd0);
    random_phase(60);
    set_page(16'($urandom_range(256, 65535)));
    random_phase(20);
    drain();
    $display("Ran %0d commands over several page sizes; %0d results, %0d compaction moves.",
             sent, result_count, move_count);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
